### src/abge_pkg.sv
// ----------------------------------------------------------------------------
// abge_pkg
// Shared constants, codes and types of the alphabet bit-group encoder.
// ----------------------------------------------------------------------------
package abge_pkg;

	localparam int ALPHABET_DEPTH    = 256;
	localparam int MAX_MESSAGE_BYTES = 1024;
	localparam int ADDR_W            = $clog2(ALPHABET_DEPTH);
	localparam int CHAR_W            = 8;
	localparam int K_W               = 4;
	localparam int MSG_W             = 11;
	localparam int BUF_W             = 15;
	localparam int HELD_W            = 4;
	localparam int SEEN_W            = 10;
	localparam int MAX_K             = 8;

	// Configuration register indexes.
	localparam logic REG_BITS_PER_SYMBOL = 1'b0;
	localparam logic REG_MESSAGE_BYTES   = 1'b1;

	// Input commands.
	localparam logic CMD_TABLE_WRITE = 1'b0;
	localparam logic CMD_DATA        = 1'b1;

	localparam logic [K_W-1:0]   BPS_RESET = K_W'(5);
	localparam logic [MSG_W-1:0] MSG_RESET = MSG_W'(16);

	// One character request from the group extractor to the output stage.
	typedef struct packed {
		logic             valid;
		logic [CHAR_W-1:0] value;
		logic             message_end;
		logic             run_last;
	} abge_issue_t;

	// Bits per character with out-of-range settings folded into 1..8.
	function automatic logic [K_W-1:0] sym_width(input logic [K_W-1:0] bps);
		logic [K_W-1:0] k;
		if (bps == '0) begin
			k = K_W'(1);
		end else if (bps > K_W'(MAX_K)) begin
			k = K_W'(MAX_K);
		end else begin
			k = bps;
		end
		return k;
	endfunction

	// Message length with out-of-range settings folded into 1..MAX_MESSAGE_BYTES.
	function automatic logic [MSG_W-1:0] msg_length(input logic [MSG_W-1:0] mb);
		logic [MSG_W-1:0] len;
		if (mb == '0) begin
			len = MSG_W'(1);
		end else if (mb > MSG_W'(MAX_MESSAGE_BYTES)) begin
			len = MSG_W'(MAX_MESSAGE_BYTES);
		end else begin
			len = mb;
		end
		return len;
	endfunction

endpackage

### src/abge_ram.sv
// ----------------------------------------------------------------------------
// abge_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module abge_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read and a write to the same entry in one cycle return the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/abge_emit.sv
// ----------------------------------------------------------------------------
// abge_emit
// Configuration registers, bit buffer and group extractor: while issue_ok
// is high, one k-bit group per cycle leaves the buffer as a table read.
// ----------------------------------------------------------------------------
module abge_emit
	import abge_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [MSG_W-1:0]  cfg_data,
	input  logic              in_valid,
	input  logic              in_cmd,
	input  logic [7:0]        in_byte,
	output logic              in_ready,
	input  logic              issue_ok,
	output abge_issue_t       issue
);

	logic [K_W-1:0]    bps_q;
	logic [MSG_W-1:0]  msg_bytes_q;
	logic [BUF_W-1:0]  buf_q;
	logic [HELD_W-1:0] held_q;
	logic [SEEN_W-1:0] seen_q;
	logic              active_q;
	logic              last_q;

	logic [K_W-1:0]    k;
	logic [HELD_W-1:0] em_held;
	logic [BUF_W-1:0]  em_shift;
	logic [MAX_K:0]    sym_mask;
	logic [BUF_W:0]    keep_mask;
	logic              em_fire;
	logic              em_final;
	logic [BUF_W-1:0]  lo_buf;
	logic [HELD_W-1:0] lo_held;
	logic [BUF_W-1:0]  base_buf;
	logic [HELD_W-1:0] base_held;
	logic              accept_data;
	logic [SEEN_W:0]   seen_next;
	logic              last_next;

	always_comb begin
		k         = sym_width(bps_q);
		em_held   = held_q - HELD_W'(k);
		em_shift  = buf_q >> em_held;
		sym_mask  = ((MAX_K+1)'(1) << k) - (MAX_K+1)'(1);
		keep_mask = ((BUF_W+1)'(1) << em_held) - (BUF_W+1)'(1);
		em_final  = em_held < HELD_W'(k);
		em_fire   = active_q && issue_ok;

		// What the buffer holds once the current byte's last group has gone.
		lo_buf    = last_q ? '0 : (buf_q & keep_mask[BUF_W-1:0]);
		lo_held   = last_q ? '0 : em_held;
		base_buf  = active_q ? lo_buf : buf_q;
		base_held = active_q ? lo_held : held_q;

		in_ready    = !active_q || (em_fire && em_final);
		accept_data = in_valid && in_ready && (in_cmd == CMD_DATA);

		seen_next = {1'b0, seen_q} + (SEEN_W+1)'(1);
		last_next = seen_next >= msg_length(msg_bytes_q);

		issue.valid       = em_fire;
		issue.value       = em_shift[CHAR_W-1:0] & sym_mask[CHAR_W-1:0];
		issue.run_last    = em_final;
		issue.message_end = em_final && last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q       <= BPS_RESET;
			msg_bytes_q <= MSG_RESET;
			buf_q       <= '0;
			held_q      <= '0;
			seen_q      <= '0;
			active_q    <= 1'b0;
			last_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BITS_PER_SYMBOL: bps_q       <= cfg_data[K_W-1:0];
				REG_MESSAGE_BYTES:   msg_bytes_q <= cfg_data;
				default:             ;
			endcase
			buf_q  <= '0;
			held_q <= '0;
			seen_q <= '0;
		end else if (accept_data) begin
			buf_q    <= {base_buf[BUF_W-9:0], in_byte};
			held_q   <= base_held + HELD_W'(8);
			active_q <= 1'b1;
			last_q   <= last_next;
			seen_q   <= last_next ? '0 : seen_next[SEEN_W-1:0];
		end else if (em_fire) begin
			if (em_final) begin
				active_q <= 1'b0;
				buf_q    <= lo_buf;
				held_q   <= lo_held;
			end else begin
				held_q <= em_held;
			end
		end
	end

`ifndef SYNTHESIS
	// Between bytes fewer than k bits remain in the buffer.
	a_idle_short : assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (held_q < HELD_W'(k)))
		else $error("leftover bits reach a full group while idle");

	// While a byte is in work at least one group is still owed.
	a_active_group : assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (held_q >= HELD_W'(k)))
		else $error("extractor active with no group left");

	// A final group with no next byte or config write leaves the extractor idle.
	a_final_idle : assert property (@(posedge clk) disable iff (!arst_n)
		(em_fire && em_final && !accept_data) |=> !active_q)
		else $error("extractor stays busy after the final group");
`endif

endmodule

### src/abge_out.sv
// ----------------------------------------------------------------------------
// abge_out
// Table read stage and output register for the character stream.
// ----------------------------------------------------------------------------
module abge_out
	import abge_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  abge_issue_t       issue,
	input  logic [CHAR_W-1:0] ram_rdata,
	output logic              issue_ok,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] out_char,
	output logic [CHAR_W-1:0] out_value,
	output logic              out_end,
	output logic              out_last
);

	logic              valid_s1;
	logic [CHAR_W-1:0] value_s1;
	logic              end_s1;
	logic              last_s1;
	logic              oob_s1;

	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic [CHAR_W-1:0] value_q;
	logic              end_q;
	logic              last_q;

	logic              adv_s1;

	// The read stage only moves when the output register frees, so the RAM
	// read data stays put while a request waits here.
	assign adv_s1   = !out_valid_q || out_ready;
	assign issue_ok = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue_ok) begin
				valid_s1 <= issue.valid;
			end
			if (adv_s1) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_ok && issue.valid) begin
			value_s1 <= issue.value;
			end_s1   <= issue.message_end;
			last_s1  <= issue.run_last;
			oob_s1   <= int'(issue.value) >= ALPHABET_DEPTH;
		end
		if (adv_s1 && valid_s1) begin
			char_q  <= oob_s1 ? '0 : ram_rdata;
			value_q <= value_s1;
			end_q   <= end_s1;
			last_q  <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = char_q;
	assign out_value = value_q;
	assign out_end   = end_q;
	assign out_last  = last_q;

`ifndef SYNTHESIS
	// A request held in the read stage keeps its group value.
	a_s1_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(value_s1)))
		else $error("read stage lost a waiting request");

	// No table read is issued while the read stage is blocked.
	a_no_issue_blocked : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> !issue_ok)
		else $error("table read issued into a blocked stage");

	// The last group of a message is also the last group of its byte.
	a_end_is_last : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && end_q) |-> last_q)
		else $error("message end without run end");
`endif

endmodule

### src/alphabet_bit_group_encoder_core.sv
// Throughput: one character per cycle while requests keep up and m_axis_tready is high;
// a data byte yields floor((held + 8) / k) characters, so 1 to 2 for k of 4 or more and
// up to 8 for k = 1. The next request can be taken as a byte's final group issues.
// The single alphabet RAM read port sets the one-per-cycle pace.
// Reset (arst_n low, asynchronous): k = 5, message length 16, bit buffer and byte count
// cleared; the alphabet RAM is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// alphabet_bit_group_encoder_core
// Encodes a byte stream into alphabet characters, k bits per character.
// ----------------------------------------------------------------------------
module alphabet_bit_group_encoder_core
	import abge_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Configuration write port
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [MSG_W-1:0]  cfg_data,
	// Request stream in
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [23:0]       s_axis_tdata,   // table_index, table_char, data_byte
	input  logic              s_axis_tuser,   // cmd
	// Character stream out
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [15:0]       m_axis_tdata,   // symbol_char, symbol_value
	output logic              m_axis_tlast,   // message_end
	output logic              m_axis_tuser    // run_last
);

	abge_issue_t       issue;
	logic              issue_ok;
	logic [CHAR_W-1:0] ram_rdata;
	logic              tbl_we;
	logic [7:0]        tbl_index;

	assign tbl_index = s_axis_tdata[7:0];
	assign tbl_we    = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_TABLE_WRITE)
	                   && (int'(tbl_index) < ALPHABET_DEPTH);

	abge_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (s_axis_tuser),
		.in_byte   (s_axis_tdata[23:16]),
		.in_ready  (s_axis_tready),
		.issue_ok  (issue_ok),
		.issue     (issue)
	);

	abge_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (ALPHABET_DEPTH)
	) u_alphabet (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_index[ADDR_W-1:0]),
		.wdata (s_axis_tdata[15:8]),
		.re    (issue.valid),
		.raddr (issue.value[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	abge_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.ram_rdata (ram_rdata),
		.issue_ok  (issue_ok),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata[7:0]),
		.out_value (m_axis_tdata[15:8]),
		.out_end   (m_axis_tlast),
		.out_last  (m_axis_tuser)
	);

endmodule

### test/abge_char_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abge_char_checker
// Watches the configuration port and both streams of the alphabet bit-group
// encoder. It keeps its own copy of the alphabet, the bit buffer and the
// message position, and checks every character against the predicted one.
// ----------------------------------------------------------------------------
module abge_char_checker
	import abge_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [MSG_W-1:0]  cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [23:0]       in_data,    // table_index, table_char, data_byte
	input  logic              in_user,    // cmd
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [15:0]       out_data,   // symbol_char, symbol_value
	input  logic              out_last,   // message_end
	input  logic              out_user,   // run_last
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic [CHAR_W-1:0] sym_char;
		logic [7:0]        sym_value;
		logic              msg_end;
		logic              run_last;
	} char_t;

	char_t             expected_chars[$];
	logic [CHAR_W-1:0] alphabet [ALPHABET_DEPTH];
	logic [K_W-1:0]    bps_reg;
	logic [MSG_W-1:0]  msg_reg;
	logic [BUF_W-1:0]  bit_store;
	int                held_bits;
	int                bytes_done;

	task automatic clear_message();
		bit_store  = '0;
		held_bits  = 0;
		bytes_done = 0;
	endtask

	// Works out every character that one data byte releases.
	task automatic encode_data_byte(input logic [7:0] data_byte);
		char_t      run [8];
		int         k;
		int         len;
		int         n;
		logic [7:0] val;
		k = (bps_reg == '0) ? 1 : (bps_reg > K_W'(MAX_K)) ? MAX_K : int'(bps_reg);
		len = (msg_reg == '0) ? 1 :
			(msg_reg > MSG_W'(MAX_MESSAGE_BYTES)) ? MAX_MESSAGE_BYTES : int'(msg_reg);
		n = 0;
		bit_store = {bit_store[BUF_W-9:0], data_byte};
		held_bits += 8;
		bytes_done++;
		while (held_bits >= k && n < 8) begin
			held_bits -= k;
			val = 8'((bit_store >> held_bits) & ((15'd1 << k) - 15'd1));
			run[n] = '{alphabet[val], val, 1'b0, 1'b0};
			n++;
		end
		bit_store &= (15'd1 << held_bits) - 15'd1;
		if (n > 0) begin
			run[n-1].run_last = 1'b1;
			run[n-1].msg_end  = (bytes_done >= len);
		end
		for (int i = 0; i < n; i++) expected_chars.insert(expected_chars.size(), run[i]);
		// The message closes on its final byte even when no character came out.
		if (bytes_done >= len) clear_message();
	endtask

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		char_t want;
		if (!arst_n) begin
			expected_chars.delete();
			bps_reg = BPS_RESET;
			msg_reg = MSG_RESET;
			clear_message();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_BITS_PER_SYMBOL) begin
					bps_reg = cfg_data[K_W-1:0];
				end else begin
					msg_reg = cfg_data;
				end
				clear_message();
			end
			if (in_valid && in_ready) begin
				if (in_user == CMD_TABLE_WRITE) begin
					alphabet[in_data[7:0]] = in_data[15:8];
				end else begin
					encode_data_byte(in_data[23:16]);
				end
			end
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					errors++;
					$display("%0t: unexpected character, expected none, got %h/%b/%b", $time,
						out_data, out_last, out_user);
				end else begin
					want = expected_chars.pop_front();
					check_field("symbol_char", want.sym_char, out_data[7:0]);
					check_field("symbol_value", want.sym_value, out_data[15:8]);
					check_field("message_end", want.msg_end, out_last);
					check_field("run_last", want.run_last, out_user);
				end
			end
			pending = expected_chars.size();
		end
	end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Loads the lower half of the alphabet, then sends directed and random data bytes through the
// encoder under a range of character widths and message lengths, with random
// gaps on the request side and random stalls on the character side.
// ----------------------------------------------------------------------------
module testbench;
	import abge_pkg::*;

	localparam int IDLE_LIMIT = 1000;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             cfg_we        = 1'b0;
	logic             cfg_index     = REG_BITS_PER_SYMBOL;
	logic [MSG_W-1:0] cfg_data      = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [23:0]      s_axis_tdata  = '0;
	logic             s_axis_tuser  = CMD_DATA;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [15:0]      m_axis_tdata;
	logic             m_axis_tlast;
	logic             m_axis_tuser;

	int errors;
	int pending;
	bit quiet       = 1'b0;
	int stall_left  = 0;
	int idle_cycles = 0;

	always #4 clk = ~clk;

	alphabet_bit_group_encoder_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	abge_char_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_user  (m_axis_tuser),
		.errors    (errors),
		.pending   (pending)
	);

	// Mostly back-to-back, sometimes a short gap, rarely a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 99) < 25) stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Holds one request until the encoder takes it; returns on the accepting edge.
	task automatic send_request(input logic cmd, input logic [7:0] index,
			input logic [7:0] char_code, input logic [7:0] data_byte);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {data_byte, char_code, index};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_byte(input logic [7:0] data_byte);
		send_request(CMD_DATA, 8'($urandom), 8'($urandom), data_byte);
	endtask

	task automatic send_entry(input logic [7:0] index, input logic [7:0] char_code);
		send_request(CMD_TABLE_WRITE, index, char_code, 8'($urandom));
	endtask

	// Waits until every character is out, then lets a trailing table write
	// settle as well.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_register(input logic index, input logic [MSG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// The unused upper bits of the width register carry noise on purpose.
	task automatic configure(input logic [K_W-1:0] bps, input logic [MSG_W-1:0] msg);
		settle();
		if ($urandom_range(0, 1) == 0) begin
			write_register(REG_BITS_PER_SYMBOL, {7'($urandom), bps});
			write_register(REG_MESSAGE_BYTES, msg);
		end else begin
			write_register(REG_MESSAGE_BYTES, msg);
			write_register(REG_BITS_PER_SYMBOL, {7'($urandom), bps});
		end
	endtask

	initial begin
		logic [MSG_W-1:0] msg;
		logic [K_W-1:0]   bps;
		int               r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Only the lower half of the alphabet is loaded up front. A group reaches
		// the upper half only at eight bits per character, and then only bytes
		// whose entries have been written are sent.
		for (int i = 0; i < ALPHABET_DEPTH / 2; i++) send_entry(8'(i), 8'($urandom));

		// Directed part under the reset settings, five bits per character.
		send_entry(8'h00, 8'h00);
		send_entry(8'hFF, 8'hFF);
		send_entry(8'h1F, 8'hA5);
		send_entry(8'hC3, 8'h3C);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		// Full-byte characters with a one-byte message.
		configure(4'd8, 11'd1);
		send_byte(8'hFF);
		send_byte(8'h00);
		// Zero width and zero length fold to one bit and one byte.
		configure(4'd0, 11'd0);
		send_byte(8'h81);
		// Widths and lengths at and above the top of the range.
		configure(4'd15, 11'd2047);
		send_byte(8'h5A);
		send_byte(8'hC3);
		configure(4'd9, 11'd1024);
		send_byte(8'h3C);
		// Leftover bits carried across bytes and dropped at message end.
		configure(4'd3, 11'd3);
		send_byte(8'hB6);
		send_byte(8'h6D);
		send_byte(8'hDB);
		send_byte(8'hFF);
		configure(4'd7, 11'd2);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'h01);

		for (int phase = 0; phase < 4; phase++) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				msg = MSG_W'($urandom_range(MAX_MESSAGE_BYTES + 1, 2047));
			end else if (r == 1) begin
				msg = MSG_W'(MAX_MESSAGE_BYTES);
			end else begin
				msg = MSG_W'($urandom_range(0, 12));
			end
			bps = K_W'($urandom_range(0, 15));
			configure(bps, msg);
			quiet = (phase % 4 == 3);
			repeat (25) begin
				if ($urandom_range(0, 9) == 0) begin
					send_entry(8'($urandom), 8'($urandom));
				end else if (bps >= K_W'(MAX_K)) begin
					// Full-byte groups stay within the loaded half of the alphabet.
					send_byte(8'($urandom_range(0, 127)));
				end else begin
					send_byte(8'($urandom));
				end
			end
		end
		quiet = 1'b0;

		settle();
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### sim.f
src/abge_pkg.sv
src/abge_ram.sv
src/abge_emit.sv
src/abge_out.sv
src/alphabet_bit_group_encoder_core.sv
test/abge_char_checker.sv
test/testbench.sv
